FILE: rtl/etc_pkg.sv
// etc_pkg: shared types, constants and helpers for the expression token classifier.
// No dependencies; compiled first.
package etc_pkg;

  // Width of the running byte position inside an expression.
  localparam int POSITION_BITS = 16;
  localparam int LEN_BITS      = 16;
  localparam int START_BITS    = 16;

  // Byte position saturates at the lesser of 2^POSITION_BITS-1 and 65535.
  localparam int POS_LIMIT_INT = (POSITION_BITS >= 16) ? 65535 : ((1 << POSITION_BITS) - 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = POSITION_BITS'(POS_LIMIT_INT);
  localparam logic [LEN_BITS-1:0]      LEN_MAX = '1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_BANG  = 8'h21;

  typedef enum logic [1:0] {
    TC_NUMBER    = 2'd0,
    TC_OPERATION = 2'd1,
    TC_INVALID   = 2'd2,
    TC_NONE      = 2'd3
  } token_class_t;

  // Per-byte class flags.
  typedef struct packed {
    logic space;
    logic digit;
    logic alpha;
    logic dot;
    logic under;
    logic sign;     // + or -
    logic single_op; // + - * / ^ !
  } char_flags_t;

  // Saturated position to the 16-bit start field (value never exceeds 65535).
  function automatic logic [START_BITS-1:0] pos_to_start(input logic [POSITION_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[START_BITS-1:0];
  endfunction

endpackage

FILE: rtl/etc_if.sv
// etc_if: valid/ready channel interfaces for the token classifier's input and result.
// Depends on etc_pkg.
interface etc_in_if;
  import etc_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       expr_end;

  modport source (output valid, output char_byte, output expr_end, input ready);
  modport sink   (input valid, input char_byte, input expr_end, output ready);
endinterface

interface etc_out_if;
  import etc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            token_class;
  logic [START_BITS-1:0] token_start;
  logic [LEN_BITS-1:0]   token_length;
  logic                  expr_last;

  modport source (output valid, output token_class, output token_start,
                  output token_length, output expr_last, input ready);
  modport sink   (input valid, input token_class, input token_start,
                  input token_length, input expr_last, output ready);
endinterface

FILE: rtl/etc_char_class.sv
// etc_char_class: decodes one expression byte into class flags.
// Depends on etc_pkg.
module etc_char_class (
  input  logic [7:0]           char_byte,
  output etc_pkg::char_flags_t flags
);
  import etc_pkg::*;

  always_comb begin
    flags.space     = (char_byte == CH_SPACE);
    flags.digit     = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    flags.alpha     = ((char_byte >= 8'h61) && (char_byte <= 8'h7A)) ||
                      ((char_byte >= 8'h41) && (char_byte <= 8'h5A));
    flags.dot       = (char_byte == CH_DOT);
    flags.under     = (char_byte == CH_UNDER);
    flags.sign      = (char_byte == CH_PLUS) || (char_byte == CH_MINUS);
    flags.single_op = flags.sign || (char_byte == CH_STAR) || (char_byte == CH_SLASH) ||
                      (char_byte == CH_CARET) || (char_byte == CH_BANG);
  end

endmodule

FILE: rtl/expression_token_classifier.sv
// expression_token_classifier: top level; tracks token state and registers one result.
// Depends on etc_pkg, etc_if (etc_in_if, etc_out_if) and etc_char_class.
//
// Usage:
//   in_ch  (sink)   one expression byte per transfer: char_byte, expr_end marks the last.
//   out_ch (source) one result per finished token: token_class, token_start,
//                   token_length, expr_last. Tokens split at space bytes only.
//   A token is reported in the transfer of the space or end byte that closes it.
//   Every expression end yields exactly one result with expr_last set; with no
//   token pending that result is class "no token" with start and length zero.
//   An invalid token suppresses further reporting until the expression ends.
// Timing:
//   One byte per cycle sustained while out_ch drains results. Result appears at out_ch
//   in the cycle after the closing byte's transfer. Bytes are decoded and the token flags
//   updated in a single combinational pass; the result register is the only pipeline stage.
//   in_ch.ready is high while the result register is empty or being drained, so a
//   stalled receiver holds at most one result and stops input only when it is full.
// Reset:
//   rst_n (synchronous, active low) clears all token state, the byte position and
//   the result register; the block accepts input in the cycle after reset.
module expression_token_classifier (
  input  logic      clk,
  input  logic      rst_n,
  etc_in_if.sink    in_ch,
  etc_out_if.source out_ch
);
  import etc_pkg::*;

  // Token tracking state
  logic                     in_token_r,       in_token_nxt;
  logic [POSITION_BITS-1:0] byte_pos_r,       byte_pos_nxt;
  logic [POSITION_BITS-1:0] start_pos_r,      start_pos_nxt;
  logic [LEN_BITS-1:0]      len_r,            len_nxt;
  logic                     in_sign_r,        in_sign_nxt;
  logic                     body_nonempty_r,  body_nonempty_nxt;
  logic                     numeric_only_r,   numeric_only_nxt;
  logic [1:0]               dot_cnt_r,        dot_cnt_nxt;
  logic                     starts_dot_r,     starts_dot_nxt;
  logic                     prev_dot_r,       prev_dot_nxt;
  logic                     ident_ok_r,       ident_ok_nxt;
  logic                     first_op_r,       first_op_nxt;   // first byte is a single op
  logic                     aborted_r,        aborted_nxt;

  // Result register
  logic                  out_valid_r;
  token_class_t          out_class_r,  out_class_nxt;
  logic [START_BITS-1:0] out_start_r,  out_start_nxt;
  logic [LEN_BITS-1:0]   out_len_r,    out_len_nxt;
  logic                  out_last_r;
  logic                  have_result;

  char_flags_t cf;
  logic        accept;

  etc_char_class u_char_class (
    .char_byte (in_ch.char_byte),
    .flags     (cf)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Token state after this byte, plus the result it may close.
  always_comb begin
    logic                     feed;
    logic                     tok;
    logic [POSITION_BITS-1:0] st;
    logic [LEN_BITS-1:0]      ln;
    logic                     sgn, nonempty, numonly, sdot, pdot, ident, fop;
    logic [1:0]               dots;
    logic                     is_num;
    token_class_t             cls;

    // Start from the live token, or from a cleared one for a fresh start.
    tok      = in_token_r;
    st       = start_pos_r;
    ln       = len_r;
    sgn      = in_sign_r;
    nonempty = body_nonempty_r;
    numonly  = numeric_only_r;
    dots     = dot_cnt_r;
    sdot     = starts_dot_r;
    pdot     = prev_dot_r;
    ident    = ident_ok_r;
    fop      = first_op_r;
    cls      = TC_NONE;
    is_num   = 1'b0;

    byte_pos_nxt = (byte_pos_r < POS_MAX) ? byte_pos_r + 1'b1 : byte_pos_r;
    aborted_nxt  = aborted_r;

    feed = !aborted_r && !cf.space;
    if (feed && !in_token_r) begin
      tok      = 1'b1;
      st       = byte_pos_r;
      ln       = '0;
      sgn      = 1'b1;
      nonempty = 1'b0;
      numonly  = 1'b1;
      dots     = 2'd0;
      sdot     = 1'b0;
      pdot     = 1'b0;
      ident    = 1'b0;
      fop      = 1'b0;
    end

    if (feed) begin
      if (ln == '0) begin
        fop   = cf.single_op;
        ident = cf.alpha;
      end else if (!(cf.alpha || cf.digit || cf.under)) begin
        ident = 1'b0;
      end
      if (ln != LEN_MAX) ln = ln + 1'b1;

      // Leading signs do not enter the numeric body.
      if (!(sgn && cf.sign)) begin
        sgn = 1'b0;
        if (!nonempty) begin
          sdot     = cf.dot;
          nonempty = 1'b1;
        end
        if (!cf.digit && !cf.dot) numonly = 1'b0;
        if (cf.dot && dots != 2'd2) dots = dots + 2'd1;
        pdot = cf.dot;
      end
    end

    is_num = nonempty && numonly && (dots != 2'd2) && !sdot && !pdot;
    priority if (is_num)                           cls = TC_NUMBER;
    else if (ident)                                cls = TC_OPERATION;
    else if ((ln == LEN_BITS'(1)) && fop)          cls = TC_OPERATION;
    else                                           cls = TC_INVALID;

    have_result   = !aborted_r && tok && (cf.space || in_ch.expr_end);
    out_class_nxt = have_result ? cls : TC_NONE;
    out_start_nxt = have_result ? pos_to_start(st) : '0;
    out_len_nxt   = have_result ? ln : '0;

    // Token closed: back to a cleared token.
    if (have_result) begin
      tok      = 1'b0;
      st       = '0;
      ln       = '0;
      sgn      = 1'b0;
      nonempty = 1'b0;
      numonly  = 1'b1;
      dots     = 2'd0;
      sdot     = 1'b0;
      pdot     = 1'b0;
      ident    = 1'b0;
      fop      = 1'b0;
      if (cls == TC_INVALID) aborted_nxt = 1'b1;
    end

    // Expression end: all per-expression state back to reset values.
    if (in_ch.expr_end) begin
      byte_pos_nxt = '0;
      aborted_nxt  = 1'b0;
      tok          = 1'b0;
      st           = '0;
      ln           = '0;
      sgn          = 1'b0;
      nonempty     = 1'b0;
      numonly      = 1'b1;
      dots         = 2'd0;
      sdot         = 1'b0;
      pdot         = 1'b0;
      ident        = 1'b0;
      fop          = 1'b0;
    end

    in_token_nxt      = tok;
    start_pos_nxt     = st;
    len_nxt           = ln;
    in_sign_nxt       = sgn;
    body_nonempty_nxt = nonempty;
    numeric_only_nxt  = numonly;
    dot_cnt_nxt       = dots;
    starts_dot_nxt    = sdot;
    prev_dot_nxt      = pdot;
    ident_ok_nxt      = ident;
    first_op_nxt      = fop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_token_r      <= 1'b0;
      byte_pos_r      <= '0;
      start_pos_r     <= '0;
      len_r           <= '0;
      in_sign_r       <= 1'b0;
      body_nonempty_r <= 1'b0;
      numeric_only_r  <= 1'b1;
      dot_cnt_r       <= 2'd0;
      starts_dot_r    <= 1'b0;
      prev_dot_r      <= 1'b0;
      ident_ok_r      <= 1'b0;
      first_op_r      <= 1'b0;
      aborted_r       <= 1'b0;
    end else if (accept) begin
      in_token_r      <= in_token_nxt;
      byte_pos_r      <= byte_pos_nxt;
      start_pos_r     <= start_pos_nxt;
      len_r           <= len_nxt;
      in_sign_r       <= in_sign_nxt;
      body_nonempty_r <= body_nonempty_nxt;
      numeric_only_r  <= numeric_only_nxt;
      dot_cnt_r       <= dot_cnt_nxt;
      starts_dot_r    <= starts_dot_nxt;
      prev_dot_r      <= prev_dot_nxt;
      ident_ok_r      <= ident_ok_nxt;
      first_op_r      <= first_op_nxt;
      aborted_r       <= aborted_nxt;
    end
  end

  // Result register: loads on a transfer that yields a result, drains on out transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && (have_result || in_ch.expr_end)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (have_result || in_ch.expr_end)) begin
      out_class_r <= out_class_nxt;
      out_start_r <= out_start_nxt;
      out_len_r   <= out_len_nxt;
      out_last_r  <= in_ch.expr_end;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_class  = out_class_r;
  assign out_ch.token_start  = out_start_r;
  assign out_ch.token_length = out_len_r;
  assign out_ch.expr_last    = out_last_r;

endmodule
